// ----- rtl/hrpd_pkg.sv -----
// Root path detector package: codes, character constants and shared types.
// No dependencies; imported by every module of the detector.
package hrpd_pkg;

  localparam int unsigned MaxPayloadDefault = 2048;

  localparam int unsigned OffsetW = 11;
  localparam int unsigned LengthW = 11;
  localparam int unsigned ReasonW = 4;
  localparam int unsigned OutDataW = 32;

  localparam logic [31:0] WordGet  = 32'h4745_5420;  // "GET "
  localparam logic [31:0] WordPost = 32'h504F_5354;  // "POST"
  localparam logic [7:0]  ChCr     = 8'h0D;
  localparam logic [7:0]  ChLf     = 8'h0A;
  localparam logic [7:0]  ChSlash  = 8'h2F;
  localparam logic [7:0]  ChSpace  = 8'h20;
  localparam logic [7:0]  ChNul    = 8'h00;

  localparam int unsigned MinPayload    = 10;
  localparam int unsigned SuffixLen     = 9;
  localparam int unsigned PostPathStart = 5;

  typedef enum logic [1:0] {
    METHOD_NONE = 2'd0,
    METHOD_GET  = 2'd1,
    METHOD_POST = 2'd2
  } method_e;

  typedef enum logic [ReasonW-1:0] {
    REASON_REWRITE  = 4'd0,
    REASON_DISABLED = 4'd1,
    REASON_SHORT    = 4'd2,
    REASON_EXTERNAL = 4'd3,
    REASON_NOT_REQ  = 4'd4,
    REASON_NO_TERM  = 4'd5,
    REASON_EMPTY    = 4'd6,
    REASON_NOT_ROOT = 4'd7,
    REASON_TOO_LONG = 4'd8
  } reason_e;

  // Packet summary handed from the tracker to the verdict logic.
  typedef struct packed {
    logic have_path;
    logic term_valid;
    logic is_request;
    logic internal;
    logic too_long;
    logic too_short;
  } pkt_flags_t;

endpackage

// ----- rtl/http_request_root_path_detector_unit.sv -----
// Top level of the HTTP request root path detector.
// Depends on hrpd_pkg, hrpd_tracker and hrpd_verdict.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata[7:0] payload byte, tlast last byte,
//           |           | tuser source internal (sampled with first byte)
//  m_axis   | out       | tdata path_offset/path_length/verdict_reason, tuser rewrite
//  cfg      | in        | cfg_we_i / cfg_wdata_i: enable bit, write-only
//
// A last byte's verdict reaches m_axis through the input register and the result
// register: the byte is held in the input register, and from there the tracker and
// verdict logic load the result register. One byte a cycle is taken sustained; only a
// last byte waits on a full result register that is not being taken.
// Reset clears the packet state and the enable bit; no clearing pass is needed.
// A stalled result holds; bytes that raise no verdict keep flowing meanwhile.
module http_request_root_path_detector_unit import hrpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] payload_byte
  input  logic                s_axis_tlast,   // last_byte
  input  logic                s_axis_tuser,   // source_internal
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [10:0] path_offset, [21:11] path_length, [25:22] verdict_reason, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser    // rewrite
);

  localparam int unsigned PosW = ($clog2(MAX_PAYLOAD + 4) > OffsetW) ?
                                 $clog2(MAX_PAYLOAD + 4) : OffsetW;

  logic            enable_q;
  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            in_src_q;
  logic            adv;
  logic            out_vld_q;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [LengthW-1:0] length_q, length_d;
  reason_e         reason_q, reason_d;
  logic            rewrite_q, rewrite_d;

  pkt_flags_t      flags;
  logic [PosW-1:0] start;
  logic [PosW-1:0] term;
  logic [15:0]     head;

  // Enable register: the user must write it only between packets; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Advance the held byte unless it is a last byte and the result slot is full and not being taken.
  assign adv           = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
      in_src_q  <= s_axis_tuser;
    end
  end

  hrpd_tracker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .src_i  (in_src_q),
    .flags_o(flags),
    .start_o(start),
    .term_o (term),
    .head_o (head)
  );

  hrpd_verdict #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_verdict (
    .enable_i (enable_q),
    .flags_i  (flags),
    .start_i  (start),
    .term_i   (term),
    .head_i   (head),
    .rewrite_o(rewrite_d),
    .offset_o (offset_d),
    .length_o (length_d),
    .reason_o (reason_d)
  );

  // Result register: load on a last byte, drop once the verdict is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      rewrite_q <= rewrite_d;
      offset_q  <= offset_d;
      length_q  <= length_d;
      reason_q  <= reason_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = rewrite_q;
  assign m_axis_tdata  = {{(OutDataW - OffsetW - LengthW - ReasonW){1'b0}},
                          reason_q, length_q, offset_q};

endmodule

// ----- rtl/hrpd_tracker.sv -----
// Per-packet byte tracker: window, CRLFCRLF automaton, method and path capture.
// Depends on hrpd_pkg.
module hrpd_tracker import hrpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault,
  localparam int unsigned PosW = ($clog2(MAX_PAYLOAD + 4) > OffsetW) ?
                                 $clog2(MAX_PAYLOAD + 4) : OffsetW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic            src_i,
  output pkt_flags_t      flags_o,
  output logic [PosW-1:0] start_o,
  output logic [PosW-1:0] term_o,
  output logic [15:0]     head_o
);

  logic [31:0]     win_q, win_d;
  logic [2:0]      crlf_q, crlf_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  method_e         method_q, method_d;
  logic            gfound_q, gfound_d;
  logic [PosW-1:0] gstart_q, gstart_d;
  logic            gtv_q, gtv_d;
  logic [PosW-1:0] gterm_q, gterm_d;
  logic [15:0]     ghead_q, ghead_d;
  logic            ptv_q, ptv_d;
  logic [PosW-1:0] pterm_q, pterm_d;
  logic [15:0]     phead_q, phead_d;
  logic            int_q, int_d;
  logic            match_get;

  localparam logic [PosW-1:0] PostStart = PosW'(PostPathStart);
  localparam logic [PosW-1:0] MaxPos    = PosW'(MAX_PAYLOAD);

  always_comb begin
    win_d     = {win_q[23:0], byte_i};
    match_get = (win_d == WordGet);
    crlf_d    = crlf_q;
    hdr_d     = hdr_q;
    gfound_d  = gfound_q;
    gstart_d  = gstart_q;
    gtv_d     = gtv_q;
    gterm_d   = gterm_q;
    ghead_d   = ghead_q;
    method_d  = method_q;
    ptv_d     = ptv_q;
    pterm_d   = pterm_q;
    phead_d   = phead_q;
    int_d     = (pos_q == '0) ? src_i : int_q;

    // Header end: CR LF CR LF, odd steps want LF, even steps want CR.
    if (!hdr_q) begin
      if (byte_i == ChCr) begin
        crlf_d = crlf_q[0] ? 3'd0 : crlf_q + 3'd1;
      end else if (byte_i == ChLf) begin
        crlf_d = crlf_q[0] ? crlf_q + 3'd1 : 3'd0;
      end else begin
        crlf_d = 3'd0;
      end
      if (crlf_d >= 3'd4) begin
        hdr_d = 1'b1;
      end
    end

    if (gfound_q) begin
      if (!gtv_q && pos_q >= gstart_q && byte_i == ChCr) begin
        gtv_d   = 1'b1;
        gterm_d = pos_q;
      end
      if (pos_q == gstart_q) begin
        ghead_d = {byte_i, ghead_q[7:0]};
      end else if (pos_q == gstart_q + PosW'(1)) begin
        ghead_d = {ghead_q[15:8], byte_i};
      end
    end else if (!hdr_d && pos_q >= PosW'(3) && match_get) begin
      gfound_d = 1'b1;
      gstart_d = pos_q + PosW'(1);
    end

    if (pos_q == PosW'(3) && match_get) begin
      method_d = METHOD_GET;
    end else if (pos_q == PosW'(4) && win_q == WordPost && byte_i == ChSpace) begin
      method_d = METHOD_POST;
    end

    if (pos_q >= PostStart && !ptv_q && byte_i == ChCr) begin
      ptv_d   = 1'b1;
      pterm_d = pos_q;
    end
    if (pos_q == PostStart) begin
      phead_d = {byte_i, phead_q[7:0]};
    end else if (pos_q == PostStart + PosW'(1)) begin
      phead_d = {phead_q[15:8], byte_i};
    end

    // Saturate one past the limit so overlong packets stay flagged.
    pos_d = (pos_q <= MaxPos) ? pos_q + PosW'(1) : pos_q;
  end

  // Summary of the packet as it stands after this byte.
  always_comb begin
    flags_o.have_path  = gfound_d || (method_d == METHOD_POST);
    flags_o.is_request = (method_d != METHOD_NONE);
    flags_o.internal   = int_d;
    flags_o.too_long   = (pos_q >= MaxPos);
    flags_o.too_short  = (pos_q < PosW'(MinPayload - 1));
    if (gfound_d) begin
      flags_o.term_valid = gtv_d;
      start_o            = gstart_d;
      term_o             = gterm_d;
      head_o             = ghead_d;
    end else begin
      flags_o.term_valid = ptv_d;
      start_o            = PostStart;
      term_o             = pterm_d;
      head_o             = phead_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      crlf_q   <= '0;
      pos_q    <= '0;
      hdr_q    <= 1'b0;
      method_q <= METHOD_NONE;
      gfound_q <= 1'b0;
      gstart_q <= '0;
      gtv_q    <= 1'b0;
      gterm_q  <= '0;
      ghead_q  <= '0;
      ptv_q    <= 1'b0;
      pterm_q  <= '0;
      phead_q  <= '0;
      int_q    <= 1'b0;
    end else if (adv_i) begin
      if (last_i) begin
        win_q    <= '0;
        crlf_q   <= '0;
        pos_q    <= '0;
        hdr_q    <= 1'b0;
        method_q <= METHOD_NONE;
        gfound_q <= 1'b0;
        gstart_q <= '0;
        gtv_q    <= 1'b0;
        gterm_q  <= '0;
        ghead_q  <= '0;
        ptv_q    <= 1'b0;
        pterm_q  <= '0;
        phead_q  <= '0;
        int_q    <= 1'b0;
      end else begin
        win_q    <= win_d;
        crlf_q   <= crlf_d;
        pos_q    <= pos_d;
        hdr_q    <= hdr_d;
        method_q <= method_d;
        gfound_q <= gfound_d;
        gstart_q <= gstart_d;
        gtv_q    <= gtv_d;
        gterm_q  <= gterm_d;
        ghead_q  <= ghead_d;
        ptv_q    <= ptv_d;
        pterm_q  <= pterm_d;
        phead_q  <= phead_d;
        int_q    <= int_d;
      end
    end
  end

endmodule

// ----- rtl/hrpd_verdict.sv -----
// Verdict logic: path length, root test and reason priority.
// Depends on hrpd_pkg.
module hrpd_verdict import hrpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault,
  localparam int unsigned PosW = ($clog2(MAX_PAYLOAD + 4) > OffsetW) ?
                                 $clog2(MAX_PAYLOAD + 4) : OffsetW
) (
  input  logic               enable_i,
  input  pkt_flags_t         flags_i,
  input  logic [PosW-1:0]    start_i,
  input  logic [PosW-1:0]    term_i,
  input  logic [15:0]        head_i,
  output logic               rewrite_o,
  output logic [OffsetW-1:0] offset_o,
  output logic [LengthW-1:0] length_o,
  output reason_e            reason_o
);

  logic [PosW-1:0] span;
  logic [PosW-1:0] plen;
  logic            root;

  always_comb begin
    span = term_i - start_i;
    plen = '0;
    if (flags_i.have_path && flags_i.term_valid && term_i >= start_i &&
        span > PosW'(SuffixLen)) begin
      plen = span - PosW'(SuffixLen);
    end
    root = (plen != '0) && (head_i[15:8] == ChSlash) &&
           ((plen == PosW'(1)) || (head_i[7:0] == ChNul));

    if (!enable_i) begin
      reason_o = REASON_DISABLED;
    end else if (flags_i.too_long) begin
      reason_o = REASON_TOO_LONG;
    end else if (flags_i.too_short) begin
      reason_o = REASON_SHORT;
    end else if (!flags_i.internal) begin
      reason_o = REASON_EXTERNAL;
    end else if (!flags_i.is_request || !flags_i.have_path) begin
      reason_o = REASON_NOT_REQ;
    end else if (!flags_i.term_valid) begin
      reason_o = REASON_NO_TERM;
    end else if (plen == '0) begin
      reason_o = REASON_EMPTY;
    end else if (!root) begin
      reason_o = REASON_NOT_ROOT;
    end else begin
      reason_o = REASON_REWRITE;
    end

    rewrite_o = (reason_o == REASON_REWRITE);
    offset_o  = flags_i.have_path ? start_i[OffsetW-1:0] : '0;
    length_o  = plen[LengthW-1:0];
  end

endmodule

// ----- rtl/hrpd_checker.sv -----
// Port-level checks for the root path detector, bound to the top level.
// Depends on hrpd_pkg and http_request_root_path_detector_unit.
module hrpd_checker import hrpd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic [ReasonW-1:0] reason;
  logic [LengthW-1:0] length;

  assign reason = m_axis_tdata[OffsetW+LengthW+ReasonW-1:OffsetW+LengthW];
  assign length = m_axis_tdata[OffsetW+LengthW-1:OffsetW];

  // Hold a stalled verdict.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("verdict dropped while stalled");

  // No verdict straight out of reset.
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("verdict right after reset");

  a_rewrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (reason == REASON_REWRITE)))
    else $error("rewrite flag disagrees with reason");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> length != '0)
    else $error("rewrite with empty path");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> reason <= REASON_TOO_LONG)
    else $error("reason code out of range");

endmodule

bind http_request_root_path_detector_unit hrpd_checker u_hrpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ----- bench/hrpd_verdict_watch.sv -----
`timescale 1ns / 100ps
// Result scoreboard for the root path detector bench: tracks every accepted payload
// byte, queues the verdict each last byte must raise and compares the result channel.
// Depends on hrpd_pkg only.
module hrpd_verdict_watch import hrpd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [7:0]          req_data_i,
  input  logic                req_last_i,
  input  logic                req_user_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  input  logic                res_user_i,
  output int                  mismatches_o,
  output int                  verdicts_due_o,
  output int                  verdicts_checked_o
);

  typedef struct packed {
    logic               rewrite;
    logic [OffsetW-1:0] offset;
    logic [LengthW-1:0] length;
    reason_e            reason;
  } verdict_t;

  logic        enable_q;
  logic [31:0] window_q;
  int unsigned crlf_q;
  int unsigned pos_q;
  logic        hdr_done_q;
  method_e     method_q;
  logic        get_seen_q;
  int unsigned get_start_q;
  logic        get_term_ok_q;
  int unsigned get_term_q;
  logic        post_term_ok_q;
  int unsigned post_term_q;
  logic [15:0] get_head_q;
  logic [15:0] post_head_q;
  logic        internal_q;

  verdict_t verdicts_due[$];
  verdict_t want;
  verdict_t got;
  int       mismatches;
  int       checked;

  function automatic void forget_packet();
    window_q       = '0;
    crlf_q         = 0;
    pos_q          = 0;
    hdr_done_q     = 1'b0;
    method_q       = METHOD_NONE;
    get_seen_q     = 1'b0;
    get_start_q    = 0;
    get_term_ok_q  = 1'b0;
    get_term_q     = 0;
    post_term_ok_q = 1'b0;
    post_term_q    = 0;
    get_head_q     = '0;
    post_head_q    = '0;
    internal_q     = 1'b0;
  endfunction

  // Advance the packet tracker by one byte; on the last byte queue its verdict.
  task automatic track_byte(input logic [7:0] b, input logic last, input logic src);
    logic [31:0] word;
    int unsigned pos;
    int unsigned total;
    int unsigned start;
    int unsigned term;
    int unsigned plen;
    logic [15:0] head;
    logic        have;
    logic        term_ok;
    logic        root;
    verdict_t    v;
    reason_e     why;
    pos  = pos_q;
    word = {window_q[23:0], b};
    if (pos == 0) internal_q = src;

    if (!hdr_done_q) begin
      if (b == ChCr) crlf_q = crlf_q[0] ? 0 : crlf_q + 1;
      else if (b == ChLf) crlf_q = crlf_q[0] ? crlf_q + 1 : 0;
      else crlf_q = 0;
      if (crlf_q >= 4) hdr_done_q = 1'b1;
    end

    if (get_seen_q) begin
      if (!get_term_ok_q && pos >= get_start_q && b == ChCr) begin
        get_term_ok_q = 1'b1;
        get_term_q    = pos;
      end
      if (pos == get_start_q) get_head_q[15:8] = b;
      else if (pos == get_start_q + 1) get_head_q[7:0] = b;
    end else if (!hdr_done_q && pos >= 3 && word == WordGet) begin
      get_seen_q  = 1'b1;
      get_start_q = pos + 1;
    end

    if (pos == 3 && word == WordGet) method_q = METHOD_GET;
    else if (pos == 4 && window_q == WordPost && b == ChSpace) method_q = METHOD_POST;

    if (pos >= PostPathStart && !post_term_ok_q && b == ChCr) begin
      post_term_ok_q = 1'b1;
      post_term_q    = pos;
    end
    if (pos == PostPathStart) post_head_q[15:8] = b;
    else if (pos == PostPathStart + 1) post_head_q[7:0] = b;

    window_q = word;
    total    = pos + 1;
    if (pos <= MAX_PAYLOAD) pos_q = pos + 1;

    if (last) begin
      have    = 1'b0;
      term_ok = 1'b0;
      start   = 0;
      term    = 0;
      plen    = 0;
      head    = '0;
      if (get_seen_q) begin
        have    = 1'b1;
        start   = get_start_q;
        term_ok = get_term_ok_q;
        term    = get_term_q;
        head    = get_head_q;
      end else if (method_q == METHOD_POST) begin
        have    = 1'b1;
        start   = PostPathStart;
        term_ok = post_term_ok_q;
        term    = post_term_q;
        head    = post_head_q;
      end
      if (have && term_ok && term >= start && term - start > SuffixLen)
        plen = term - start - SuffixLen;
      root = plen > 0 && head[15:8] == ChSlash && (plen == 1 || head[7:0] == ChNul);

      if (!enable_q) why = REASON_DISABLED;
      else if (total > MAX_PAYLOAD) why = REASON_TOO_LONG;
      else if (total < MinPayload) why = REASON_SHORT;
      else if (!internal_q) why = REASON_EXTERNAL;
      else if (method_q == METHOD_NONE || !have) why = REASON_NOT_REQ;
      else if (!term_ok) why = REASON_NO_TERM;
      else if (plen == 0) why = REASON_EMPTY;
      else if (!root) why = REASON_NOT_ROOT;
      else why = REASON_REWRITE;

      v.rewrite = (why == REASON_REWRITE);
      v.offset  = have ? start[OffsetW-1:0] : '0;
      v.length  = plen[LengthW-1:0];
      v.reason  = why;
      verdicts_due.push_back(v);
      forget_packet();
    end
  endtask

  function automatic void note_mismatch(string what, verdict_t w, verdict_t g,
                                        logic [OutDataW-1:0] raw);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: want rewrite %0b offset %0d length %0d reason %0d",
               $time, what, w.rewrite, w.offset, w.length, w.reason);
      $display("    got rewrite %0b offset %0d length %0d reason %0d (tdata %h)",
               g.rewrite, g.offset, g.length, g.reason, raw);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q = 1'b0;
      forget_packet();
      verdicts_due.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_we_i) enable_q = cfg_wdata_i;
      if (req_valid_i && req_ready_i) track_byte(req_data_i, req_last_i, req_user_i);
      if (res_valid_i && res_ready_i) begin
        got.rewrite = res_user_i;
        got.offset  = res_data_i[10:0];
        got.length  = res_data_i[21:11];
        got.reason  = reason_e'(res_data_i[25:22]);
        if (verdicts_due.size() == 0) begin
          note_mismatch("verdict with none due", '0, got, res_data_i);
        end else begin
          want = verdicts_due.pop_front();
          checked++;
          if (got.rewrite !== want.rewrite || got.offset !== want.offset ||
              got.length !== want.length || got.reason !== want.reason ||
              res_data_i[OutDataW-1:26] !== '0)
            note_mismatch("verdict mismatch", want, got, res_data_i);
        end
      end
    end
    mismatches_o       <= mismatches;
    verdicts_due_o     <= verdicts_due.size();
    verdicts_checked_o <= checked;
  end

endmodule

// ----- bench/http_request_root_path_detector_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the root path detector bench: clock, reset, request and result pacing,
// directed and random packets and the run verdict.
// Depends on hrpd_pkg, hrpd_verdict_watch and http_request_root_path_detector_unit.
module http_request_root_path_detector_unit_tb;
  import hrpd_pkg::*;

  localparam int unsigned MaxPayload    = MaxPayloadDefault;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 300;
  // covers the path from request to verdict, plus margin
  localparam int unsigned SettleCycles  = 6;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pace_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  int mismatches;
  int verdicts_due;
  int verdicts_checked;

  pace_e       pace = PACE_FULL;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int unsigned cycles = 0;
  logic [7:0]  frame[$];

  http_request_root_path_detector_unit #(
    .MAX_PAYLOAD(MaxPayload)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hrpd_verdict_watch #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_watch (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .req_valid_i        (s_axis_tvalid),
    .req_ready_i        (s_axis_tready),
    .req_data_i         (s_axis_tdata),
    .req_last_i         (s_axis_tlast),
    .req_user_i         (s_axis_tuser),
    .res_valid_i        (m_axis_tvalid),
    .res_ready_i        (m_axis_tready),
    .res_data_i         (m_axis_tdata),
    .res_user_i         (m_axis_tuser),
    .mismatches_o       (mismatches),
    .verdicts_due_o     (verdicts_due),
    .verdicts_checked_o (verdicts_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("http_request_root_path_detector_unit_tb NOT OK");
      $finish;
    end
  end

  // Result side: stall at the rate the pace asks, or hold off entirely for a
  // long stretch when the stimulus requests it, so the detector backs up.
  initial begin
    int unsigned stall_pct;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldOffCycles;
      end
      stall_pct = (pace == PACE_SINK_STALL) ? 83 : (pace == PACE_BOTH) ? 9 : 0;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Push the queued frame byte by byte; tuser carries the source flag on the
  // first byte and random junk afterwards, which the detector must ignore.
  // valid stays high after the last handshake so the next frame follows
  // without a bubble; drop it with settle() before doing anything else.
  task automatic send_frame(input logic src);
    int unsigned idle_pct;
    idle_pct = (pace == PACE_SENDER_IDLE) ? 83 : (pace == PACE_BOTH) ? 9 : 0;
    for (int i = 0; i < frame.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame[i];
      s_axis_tlast  <= (i == frame.size() - 1);
      s_axis_tuser  <= (i == 0) ? src : 1'($urandom_range(1));
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      bytes_sent++;
    end
    frame.delete();
    packets_sent++;
  endtask

  // Hold the request side idle until every queued verdict has been taken.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    settle();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  // Bias towards the bytes the tracker reacts to.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(11))
      0:       return ChCr;
      1:       return ChLf;
      2:       return "G";
      3:       return "E";
      4:       return "T";
      5:       return ChSpace;
      6:       return ChSlash;
      7:       return ChNul;
      8:       return "P";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void put_path();
    case ($urandom_range(7))
      0, 1: frame.push_back(ChSlash);
      2: begin
        // root ended early by a NUL, as a C string would read it
        frame.push_back(ChSlash);
        frame.push_back(ChNul);
        repeat ($urandom_range(4)) frame.push_back(noise_char());
      end
      3: ;
      4: repeat ($urandom_range(1, 3)) frame.push_back(noise_char());
      default: begin
        frame.push_back(ChSlash);
        repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(33, 126)));
      end
    endcase
  endfunction

  // Version suffix or filler, optional request line end with up to two headers and header end, then body.
  function automatic void put_tail();
    if ($urandom_range(99) < 80) begin
      put_text(" HTTP/1.");
      frame.push_back(8'("0" + $urandom_range(9)));
    end else begin
      repeat ($urandom_range(8)) frame.push_back("h");
    end
    if ($urandom_range(99) < 85) begin
      put_text("\015\012");
      repeat ($urandom_range(2)) begin
        if ($urandom_range(5) == 0) put_text("Via: GET / HTTP/1.1");
        else put_text("Host: h");
        repeat ($urandom_range(3)) frame.push_back(noise_char());
        put_text("\015\012");
      end
      if ($urandom_range(99) < 70) put_text("\015\012");
    end
    repeat ($urandom_range(6)) frame.push_back(noise_char());
  endfunction

  // Mostly well-formed requests with random paths; the rest near misses,
  // truncated requests, short packets and plain noise.
  function automatic void build_random_frame();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      put_text("GET ");
      put_path();
      put_tail();
    end else if (roll < 55) begin
      put_text("POST ");
      put_path();
      put_tail();
    end else if (roll < 63) begin
      repeat ($urandom_range(1, 6)) frame.push_back(noise_char());
      put_text("GET ");
      put_path();
      put_tail();
    end else if (roll < 70) begin
      if (roll[0]) put_text("GET ");
      else put_text("POST ");
      put_path();
      repeat ($urandom_range(8)) frame.push_back("a");
    end else if (roll < 78) begin
      repeat ($urandom_range(1, 9)) frame.push_back(noise_char());
    end else if (roll < 88) begin
      case ($urandom_range(3))
        0: put_text("GET/ ");
        1: put_text("POSTX");
        2: put_text("get ");
        default: put_text("POS T");
      endcase
      put_path();
      put_tail();
    end else begin
      repeat ($urandom_range(1, 40)) frame.push_back(noise_char());
    end
  endfunction

  initial begin
    int    start_bytes;
    int    start_pkts;
    int    target;
    pace_e phase_pace[5];
    logic  phase_enable[5];
    phase_pace   = '{PACE_FULL, PACE_SENDER_IDLE, PACE_SINK_STALL, PACE_FULL, PACE_BOTH};
    phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets; \015\012 is CR LF.
    write_enable(1'b1);
    put_text("GET / HTTP/1.1\015\012Host: a\015\012\015\012");
    send_frame(1'b1);
    put_text("GET / HTTP/1.1\015\012Host: a\015\012\015\012");
    send_frame(1'b0);                                   // external source
    put_text("GET /index.htm HTTP/1.1\015\012\015\012");
    send_frame(1'b1);                                   // not root
    put_text("POST / HTTP/1.0\015\012\015\012");
    send_frame(1'b1);                                   // root via POST
    put_text("POST /");
    frame.push_back(ChNul);
    put_text("ab HTTP/1.1\015\012");
    send_frame(1'b1);                                   // root cut by NUL
    put_text("GET /");
    frame.push_back(ChNul);
    put_text("z HTTP/1.1\015\012");
    send_frame(1'b1);
    put_text("GET  HTTP/1.1\015\012\015\012");
    send_frame(1'b1);                                   // empty path
    put_text("GET /abcdefgh");
    send_frame(1'b1);                                   // no CR before the end
    put_text("GET / HTT");
    send_frame(1'b1);                                   // one byte under the minimum
    put_text("GET /\015ABCD");
    send_frame(1'b1);                                   // exactly the minimum
    frame.push_back(8'hFF);
    send_frame(1'b1);                                   // single byte packet
    repeat (12) frame.push_back(ChNul);
    send_frame(1'b1);
    put_text("XGET / HTTP/1.1\015\012\015\012");
    send_frame(1'b1);                                   // GET found, no method
    put_text("POST /x HTTP/1.1\015\012A: GET / HTTP/1.1\015\012\015\012");
    send_frame(1'b1);                                   // later GET overrides POST path
    put_text("\015\012\015\012GET / HTTP/1.1\015\012");
    send_frame(1'b1);                                   // GET after header end
    put_text("\015\015\012\015\012GET / HTTP/1.1\015\012");
    send_frame(1'b1);                                   // broken CR LF run
    put_text("POSTx/ HTTP/1.1\015\012");
    send_frame(1'b1);
    put_text("GET / HTTP/1.1\015");
    send_frame(1'b1);                                   // CR on the last byte
    put_text("GET /a/b HTTP/1.1\015\012");
    send_frame(1'b1);
    put_text("POST \015\012\015\012ab");
    send_frame(1'b1);
    // Largest packet that is still in range, with no terminator.
    put_text("GET /");
    repeat (MaxPayload - 5) frame.push_back("x");
    send_frame(1'b1);
    // Overlong packet: GET path starts past the offset range, counter saturates.
    repeat (MaxPayload - 4) frame.push_back("a");
    put_text("GET / HTTP/1.1\015");
    send_frame(1'b1);

    // Detection off: every verdict is disabled.
    write_enable(1'b0);
    put_text("GET / HTTP/1.1\015\012\015\012");
    send_frame(1'b1);
    frame.push_back(8'hFF);
    send_frame(1'b1);

    // Random phases, one per pacing pattern plus a second full-rate phase with detection off.
    for (int ph = 0; ph < 5; ph++) begin
      write_enable(phase_enable[ph]);
      pace        = phase_pace[ph];
      target      = phase_enable[ph] ? 240 : 140;
      start_bytes = bytes_sent;
      start_pkts  = packets_sent;
      if (ph == 0) begin
        // Hold the result side off and keep offering, so the detector backs up.
        hold_requests++;
        repeat (8) begin
          build_random_frame();
          send_frame($urandom_range(99) < 80);
        end
      end
      while (bytes_sent - start_bytes < target || packets_sent - start_pkts < 12) begin
        if ($urandom_range(39) == 0) settle();
        build_random_frame();
        send_frame($urandom_range(99) < 80);
      end
    end

    settle();
    repeat (SettleCycles) @(posedge clk);
    $display("Run covered %0d payload bytes in %0d packets, %0d verdicts compared.",
             bytes_sent, packets_sent, verdicts_checked);
    $display("Detection on/off, four pacing patterns, a long result hold-off, overlong packets.");
    if (mismatches == 0 && verdicts_due == 0) begin
      $display("http_request_root_path_detector_unit_tb OK");
    end else begin
      $display("http_request_root_path_detector_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
